>>> hw/rtl/sgsu_pkg.sv
// shared types, constants and helpers for the sparse gate state update block
package sgsu_pkg;

  localparam int MAX_QUBITS     = 10;
  localparam int AMP_FRAC_BITS  = 14;
  localparam int IDX_W          = 10;
  localparam int AMP_W          = 16;
  localparam int QC_W           = 4;
  localparam int QUEUE_DEPTH    = 2;
  localparam int PROD_W         = 2 * AMP_W;
  localparam int DIFF_W         = PROD_W + 1;
  localparam int SUM_W          = DIFF_W + 1;
  localparam int S_TDATA_W      = 56;
  localparam int S_TUSER_W      = 2;
  localparam int M_TDATA_W      = 40;

  localparam logic [QC_W-1:0] QC_RESET = QC_W'(10);

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ACC    = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic {
    ST_DONE  = 1'b0,
    ST_RANGE = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_EXEC,
    BK_SUM,
    BK_ACC,
    BK_CLR
  } back_state_e;

  typedef struct packed {
    cmd_e                    cmd;
    logic                    oob;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [AMP_W-1:0] vre;
    logic signed [AMP_W-1:0] vim;
  } item_t;

  typedef struct packed {
    status_e                 status;
    logic signed [AMP_W-1:0] amp_re;
    logic signed [AMP_W-1:0] amp_im;
  } result_t;

  function automatic logic signed [AMP_W-1:0] sat_amp(input logic signed [SUM_W-1:0] x);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(16'sh7fff);
    lo = SUM_W'(16'sh8000);
    if (x > hi) begin
      return 16'sh7fff;
    end else if (x < lo) begin
      return 16'sh8000;
    end else begin
      return AMP_W'(x);
    end
  endfunction

endpackage

>>> hw/rtl/sgsu_ram.sv
// simple dual-port amplitude ram with registered read data
module sgsu_ram #(
  parameter int AddrW = sgsu_pkg::MAX_QUBITS,
  parameter int DataW = 2 * sgsu_pkg::AMP_W
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  localparam int Depth = 1 << AddrW;

  logic [DataW-1:0] mem [Depth];
  logic [DataW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sgsu_front.sv
// front end: qubit count register, request intake and index range classification
module sgsu_front #(
  parameter int MaxQubits = sgsu_pkg::MAX_QUBITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sgsu_pkg::QC_W-1:0]      cfg_wdata_i,
  input  logic                           s_valid_i,
  input  logic [sgsu_pkg::S_TDATA_W-1:0] s_data_i,
  input  logic [sgsu_pkg::S_TUSER_W-1:0] s_user_i,
  output logic                           s_ready_o,
  input  logic                           q_full_i,
  input  logic                           init_done_i,
  output logic                           push_o,
  output sgsu_pkg::item_t                item_o
);

  logic [sgsu_pkg::QC_W-1:0]  qc_q;
  logic [sgsu_pkg::QC_W-1:0]  qc_eff;
  logic [sgsu_pkg::IDX_W-1:0] row;
  logic [sgsu_pkg::IDX_W-1:0] col;
  logic                       row_oob;
  logic                       col_oob;
  sgsu_pkg::cmd_e             cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qc_q <= sgsu_pkg::QC_RESET;
    end else if (cfg_we_i) begin
      qc_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    qc_eff = qc_q;
    if (int'(qc_q) > MaxQubits) begin
      qc_eff = sgsu_pkg::QC_W'(MaxQubits);
    end
  end

  assign cmd     = sgsu_pkg::cmd_e'(s_user_i);
  assign row     = s_data_i[sgsu_pkg::IDX_W-1:0];
  assign col     = s_data_i[2*sgsu_pkg::IDX_W-1:sgsu_pkg::IDX_W];
  assign row_oob = (row >> qc_eff) != '0;
  assign col_oob = (col >> qc_eff) != '0;

  always_comb begin
    item_o.cmd = cmd;
    item_o.row = row;
    item_o.col = col;
    item_o.vre = s_data_i[2*sgsu_pkg::IDX_W +: sgsu_pkg::AMP_W];
    item_o.vim = s_data_i[2*sgsu_pkg::IDX_W+sgsu_pkg::AMP_W +: sgsu_pkg::AMP_W];
    case (cmd)
      sgsu_pkg::CMD_LOAD:   item_o.oob = row_oob;
      sgsu_pkg::CMD_ACC:    item_o.oob = row_oob | col_oob;
      sgsu_pkg::CMD_COMMIT: item_o.oob = 1'b0;
      sgsu_pkg::CMD_READ:   item_o.oob = row_oob;
      default:              item_o.oob = 1'b0;
    endcase
  end

  assign s_ready_o = init_done_i & ~q_full_i;
  assign push_o    = s_valid_i & s_ready_o;

endmodule

>>> hw/rtl/sgsu_fifo.sv
// short request queue between front end and back end
module sgsu_fifo #(
  parameter int Depth = sgsu_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  sgsu_pkg::item_t item_i,
  output logic            full_o,
  input  logic            pop_i,
  output sgsu_pkg::item_t item_o,
  output logic            empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  sgsu_pkg::item_t slot_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  assign item_o  = slot_q[rptr_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

endmodule

>>> hw/rtl/sgsu_back.sv
// back end: amplitude stores, complex multiply-accumulate, commit sweep and result register
module sgsu_back #(
  parameter int MaxQubits = sgsu_pkg::MAX_QUBITS,
  parameter int FracBits  = sgsu_pkg::AMP_FRAC_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sgsu_pkg::item_t  head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             init_done_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output sgsu_pkg::result_t res_o
);

  localparam int AddrW = MaxQubits;
  localparam int DataW = 2 * sgsu_pkg::AMP_W;
  localparam int AW    = sgsu_pkg::AMP_W;

  sgsu_pkg::back_state_e state_q, state_d;
  logic                  sel_q, sel_d;
  logic [AddrW-1:0]      cnt_q, cnt_d;
  logic                  res_valid_q, res_valid_d;
  sgsu_pkg::result_t     res_q, res_d;
  sgsu_pkg::item_t       work_q;

  logic signed [sgsu_pkg::PROD_W-1:0] prr_q, pii_q, pri_q, pir_q;
  logic signed [sgsu_pkg::DIFF_W-1:0] shr_q, shi_q;
  logic signed [sgsu_pkg::DIFF_W-1:0] diff_re, diff_im;
  logic signed [sgsu_pkg::SUM_W-1:0]  sum_re, sum_im;

  logic [AddrW-1:0] cur_raddr, nxt_raddr;
  logic [DataW-1:0] cur_rdata, nxt_rdata;
  logic             cur_we, nxt_we;
  logic [AddrW-1:0] cur_waddr, nxt_waddr;
  logic [DataW-1:0] cur_wdata, nxt_wdata;

  logic             a_we, b_we;
  logic [AddrW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [DataW-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

  logic signed [AW-1:0] cur_re, cur_im, nxt_re, nxt_im;

  assign cur_raddr = (head_i.cmd == sgsu_pkg::CMD_ACC) ? AddrW'(head_i.col)
                                                       : AddrW'(head_i.row);
  assign nxt_raddr = AddrW'(head_i.row);

  assign a_raddr   = sel_q ? nxt_raddr : cur_raddr;
  assign b_raddr   = sel_q ? cur_raddr : nxt_raddr;
  assign cur_rdata = sel_q ? b_rdata : a_rdata;
  assign nxt_rdata = sel_q ? a_rdata : b_rdata;

  assign a_we    = sel_q ? nxt_we : cur_we;
  assign a_waddr = sel_q ? nxt_waddr : cur_waddr;
  assign a_wdata = sel_q ? nxt_wdata : cur_wdata;
  assign b_we    = sel_q ? cur_we : nxt_we;
  assign b_waddr = sel_q ? cur_waddr : nxt_waddr;
  assign b_wdata = sel_q ? cur_wdata : nxt_wdata;

  sgsu_ram #(.AddrW(AddrW), .DataW(DataW)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (a_waddr),
    .wdata_i (a_wdata),
    .re_i    (pop_o),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  sgsu_ram #(.AddrW(AddrW), .DataW(DataW)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (pop_o),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  assign cur_re = $signed(cur_rdata[AW-1:0]);
  assign cur_im = $signed(cur_rdata[DataW-1:AW]);
  assign nxt_re = $signed(nxt_rdata[AW-1:0]);
  assign nxt_im = $signed(nxt_rdata[DataW-1:AW]);

  assign diff_re = sgsu_pkg::DIFF_W'(prr_q) - sgsu_pkg::DIFF_W'(pii_q);
  assign diff_im = sgsu_pkg::DIFF_W'(pri_q) + sgsu_pkg::DIFF_W'(pir_q);
  assign sum_re  = sgsu_pkg::SUM_W'(shr_q) + sgsu_pkg::SUM_W'(nxt_re);
  assign sum_im  = sgsu_pkg::SUM_W'(shi_q) + sgsu_pkg::SUM_W'(nxt_im);

  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    cnt_d       = cnt_q;
    res_valid_d = res_valid_q;
    res_d       = res_q;
    pop_o       = 1'b0;
    cur_we      = 1'b0;
    cur_waddr   = AddrW'(work_q.row);
    cur_wdata   = {work_q.vim, work_q.vre};
    nxt_we      = 1'b0;
    nxt_waddr   = AddrW'(work_q.row);
    nxt_wdata   = {sgsu_pkg::sat_amp(sum_im), sgsu_pkg::sat_amp(sum_re)};

    if (res_valid_q && res_ready_i) begin
      res_valid_d = 1'b0;
    end

    case (state_q)
      sgsu_pkg::BK_INIT: begin
        cur_we    = 1'b1;
        cur_waddr = cnt_q;
        cur_wdata = '0;
        nxt_we    = 1'b1;
        nxt_waddr = cnt_q;
        nxt_wdata = '0;
        cnt_d     = cnt_q + AddrW'(1);
        if (cnt_q == '1) begin
          state_d = sgsu_pkg::BK_IDLE;
        end
      end
      sgsu_pkg::BK_IDLE: begin
        if (!empty_i && (!res_valid_q || res_ready_i)) begin
          pop_o   = 1'b1;
          state_d = sgsu_pkg::BK_EXEC;
        end
      end
      sgsu_pkg::BK_EXEC: begin
        res_d.status = sgsu_pkg::ST_DONE;
        res_d.amp_re = '0;
        res_d.amp_im = '0;
        state_d      = sgsu_pkg::BK_IDLE;
        res_valid_d  = 1'b1;
        if (work_q.oob) begin
          res_d.status = sgsu_pkg::ST_RANGE;
        end else begin
          case (work_q.cmd)
            sgsu_pkg::CMD_LOAD: begin
              cur_we = 1'b1;
            end
            sgsu_pkg::CMD_ACC: begin
              res_valid_d = res_valid_q;
              state_d     = sgsu_pkg::BK_SUM;
            end
            sgsu_pkg::CMD_COMMIT: begin
              sel_d   = ~sel_q;
              cnt_d   = '0;
              state_d = sgsu_pkg::BK_CLR;
            end
            sgsu_pkg::CMD_READ: begin
              res_d.amp_re = cur_re;
              res_d.amp_im = cur_im;
            end
            default: begin
              state_d = sgsu_pkg::BK_IDLE;
            end
          endcase
        end
      end
      sgsu_pkg::BK_SUM: begin
        state_d = sgsu_pkg::BK_ACC;
      end
      sgsu_pkg::BK_ACC: begin
        nxt_we       = 1'b1;
        res_d.status = sgsu_pkg::ST_DONE;
        res_d.amp_re = '0;
        res_d.amp_im = '0;
        res_valid_d  = 1'b1;
        state_d      = sgsu_pkg::BK_IDLE;
      end
      sgsu_pkg::BK_CLR: begin
        nxt_we    = 1'b1;
        nxt_waddr = cnt_q;
        nxt_wdata = '0;
        cnt_d     = cnt_q + AddrW'(1);
        if (cnt_q == '1) begin
          state_d = sgsu_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = sgsu_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sgsu_pkg::BK_INIT;
      sel_q       <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (pop_o) begin
      work_q <= head_i;
    end
    if (state_q == sgsu_pkg::BK_EXEC) begin
      prr_q <= work_q.vre * cur_re;
      pii_q <= work_q.vim * cur_im;
      pri_q <= work_q.vre * cur_im;
      pir_q <= work_q.vim * cur_re;
    end
    if (state_q == sgsu_pkg::BK_SUM) begin
      shr_q <= diff_re >>> FracBits;
      shi_q <= diff_im >>> FracBits;
    end
  end

  assign init_done_o = (state_q != sgsu_pkg::BK_INIT);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> hw/rtl/sparse_gate_state_update.sv
// load, read, commit and range errors post their result from the exec state; accumulate goes
// through the exec, sum and acc states before its result; the single back-end sequencer works
// through the two amplitude rams one request at a time, taking a new one only once the last is done
// commit flips the ram roles and then sweeps all 2^MaxQubits entries zeroing the new next vector
// after reset every entry of both rams is zeroed with s_axis_tready held low;
// configuration writes are taken throughout
module sparse_gate_state_update #(
  parameter int MaxQubits = sgsu_pkg::MAX_QUBITS,
  parameter int FracBits  = sgsu_pkg::AMP_FRAC_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sgsu_pkg::QC_W-1:0]      cfg_wdata_i,   // qubit_count
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sgsu_pkg::S_TDATA_W-1:0] s_axis_tdata,  // row_index, col_index, value_re, value_im
  input  logic [sgsu_pkg::S_TUSER_W-1:0] s_axis_tuser,  // cmd
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sgsu_pkg::M_TDATA_W-1:0] m_axis_tdata   // status, amp_re, amp_im
);

  logic              push, pop, q_full, q_empty, init_done;
  sgsu_pkg::item_t   push_item, head_item;
  sgsu_pkg::result_t res;

  sgsu_front #(.MaxQubits(MaxQubits)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .s_ready_o   (s_axis_tready),
    .q_full_i    (q_full),
    .init_done_i (init_done),
    .push_o      (push),
    .item_o      (push_item)
  );

  sgsu_fifo #(.Depth(sgsu_pkg::QUEUE_DEPTH)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .item_o  (head_item),
    .empty_o (q_empty)
  );

  sgsu_back #(.MaxQubits(MaxQubits), .FracBits(FracBits)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_item),
    .empty_i     (q_empty),
    .pop_o       (pop),
    .init_done_o (init_done),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {7'd0, res.amp_im, res.amp_re, res.status};

  a_pop_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_empty)
    else $error("request taken from empty queue");

  a_pop_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !pop)
    else $error("back end took two requests in consecutive cycles");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("request pushed into full queue");

endmodule

>>> dv/sparse_gate_state_update_tb.sv
// self-checking testbench for the sparse gate state update block: directed and random requests
module sparse_gate_state_update_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sgsu_pkg::*;

  typedef struct packed {
    logic signed [AMP_W-1:0] re;
    logic signed [AMP_W-1:0] im;
  } amp_t;

  typedef struct {
    cmd_e                    cmd;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [AMP_W-1:0] vre;
    logic signed [AMP_W-1:0] vim;
  } gate_req_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [QC_W-1:0]      cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  gate_req_t       pending_reqs[$];
  result_t         expected_amps[$];
  amp_t            state_amp[2**MAX_QUBITS];
  amp_t            accum_amp[2**MAX_QUBITS];
  logic [QC_W-1:0] qubits = QC_RESET;
  gate_req_t       active_req;
  gate_req_t       drv_req;
  result_t         mon_want;
  result_t         mon_got;
  int              gap_cnt = 0;
  int              stall_cnt = 0;
  int              stall_nxt;
  int              hold_left = 0;
  bit              held_once = 1'b0;
  bit              quiet = 1'b0;
  int              queued_cnt = 0;
  int              accepted_cnt = 0;
  int              errors = 0;
  int              phase_qubits[9] = '{3, 1, 10, 2, 15, 0, 4, 10, 6};

  sparse_gate_state_update dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int vec_len();
    return 1 << ((qubits > MAX_QUBITS) ? MAX_QUBITS : qubits);
  endfunction

  function automatic logic signed [AMP_W-1:0] clamp_amp(input longint x);
    if (x > 32767) return 16'sh7fff;
    if (x < -32768) return 16'sh8000;
    return x[AMP_W-1:0];
  endfunction

  function automatic void apply_gate_request(input gate_req_t req);
    result_t res;
    int      len;
    longint  pre;
    longint  pim;
    amp_t    src;
    amp_t    dst;
    len = vec_len();
    res.status = ST_DONE;
    res.amp_re = '0;
    res.amp_im = '0;
    case (req.cmd)
      CMD_LOAD: begin
        if (req.row >= len) res.status = ST_RANGE;
        else state_amp[req.row] = '{re: req.vre, im: req.vim};
      end
      CMD_ACC: begin
        if (req.row >= len || req.col >= len) begin
          res.status = ST_RANGE;
        end else begin
          src = state_amp[req.col];
          dst = accum_amp[req.row];
          pre = longint'(req.vre) * longint'(src.re) - longint'(req.vim) * longint'(src.im);
          pim = longint'(req.vre) * longint'(src.im) + longint'(req.vim) * longint'(src.re);
          dst.re = clamp_amp(longint'(dst.re) + (pre >>> AMP_FRAC_BITS));
          dst.im = clamp_amp(longint'(dst.im) + (pim >>> AMP_FRAC_BITS));
          accum_amp[req.row] = dst;
        end
      end
      CMD_COMMIT: begin
        foreach (state_amp[i]) begin
          state_amp[i] = accum_amp[i];
          accum_amp[i] = '0;
        end
      end
      default: begin
        if (req.row >= len) begin
          res.status = ST_RANGE;
        end else begin
          res.amp_re = state_amp[req.row].re;
          res.amp_im = state_amp[req.row].im;
        end
      end
    endcase
    expected_amps.insert(expected_amps.size(), res);
  endfunction

  function automatic logic signed [AMP_W-1:0] rand_amp();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'sh4000;
      3: return AMP_W'(int'($urandom_range(0, 64)) - 32);
      default: return AMP_W'($urandom);
    endcase
  endfunction

  function automatic int in_range(input int len);
    return $urandom_range(0, len - 1);
  endfunction

  function automatic int out_range(input int len);
    return (len < 2**IDX_W) ? $urandom_range(len, 2**IDX_W - 1) : $urandom_range(0, 2**IDX_W - 1);
  endfunction

  task automatic queue_req(input cmd_e cmd, input int row, input int col,
                           input logic signed [AMP_W-1:0] vre, input logic signed [AMP_W-1:0] vim);
    gate_req_t r;
    r.cmd = cmd;
    r.row = row[IDX_W-1:0];
    r.col = col[IDX_W-1:0];
    r.vre = vre;
    r.vim = vim;
    pending_reqs.insert(pending_reqs.size(), r);
    queued_cnt++;
  endtask

  task automatic add_noise(input int len);
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 2))
        0: queue_req(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 1023), $urandom_range(0, 1023),
                     AMP_W'($urandom), AMP_W'($urandom));
        1: queue_req(CMD_ACC, in_range(len), out_range(len), rand_amp(), rand_amp());
        default: queue_req(cmd_e'($urandom_range(0, 3)), out_range(len), in_range(len),
                           rand_amp(), rand_amp());
      endcase
    end
  endtask

  // load a few amplitudes, accumulate sparse entries over them, commit, read back
  task automatic add_round(input int len);
    int picks[8];
    int k;
    int n_acc;
    k = (len < 8) ? len : 8;
    for (int i = 0; i < k; i++) picks[i] = (len <= 8) ? i : in_range(len);
    for (int i = 0; i < k; i++) begin
      add_noise(len);
      queue_req(CMD_LOAD, picks[i], $urandom_range(0, 1023), rand_amp(), rand_amp());
    end
    n_acc = $urandom_range(2, 14);
    repeat (n_acc) begin
      add_noise(len);
      queue_req(CMD_ACC, picks[$urandom_range(0, k - 1)], picks[$urandom_range(0, k - 1)],
                rand_amp(), rand_amp());
    end
    queue_req(CMD_COMMIT, $urandom_range(0, 1023), $urandom_range(0, 1023),
              AMP_W'($urandom), AMP_W'($urandom));
    for (int i = 0; i < k; i++) begin
      add_noise(len);
      queue_req(CMD_READ, picks[i], $urandom_range(0, 1023), rand_amp(), rand_amp());
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_amps.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_qubits(input logic [QC_W-1:0] v);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    qubits = v;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_gate_request(active_req);
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_cnt != 0) begin
          gap_cnt <= gap_cnt - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_reqs.size() != 0) begin
          drv_req = pending_reqs.pop_front();
          active_req <= drv_req;
          s_axis_tdata <= S_TDATA_W'({drv_req.vim, drv_req.vre, drv_req.col, drv_req.row});
          s_axis_tuser <= drv_req.cmd;
          s_axis_tvalid <= 1'b1;
          gap_cnt <= quiet ? 0 : $urandom_range(0, 11);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // one long receiver stall while requests keep coming
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!held_once && accepted_cnt >= 300 && queued_cnt - accepted_cnt > 40) begin
      hold_left <= 300;
      held_once <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      stall_nxt = stall_cnt;
      if (m_axis_tvalid && m_axis_tready) begin
        mon_got.status = status_e'(m_axis_tdata[0]);
        mon_got.amp_re = m_axis_tdata[16:1];
        mon_got.amp_im = m_axis_tdata[32:17];
        if (expected_amps.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, expected none actual %h", $time, m_axis_tdata);
        end else begin
          mon_want = expected_amps.pop_front();
          if (mon_got.status != mon_want.status) begin
            errors++;
            $display("%0t: status expected %0d actual %0d", $time, mon_want.status, mon_got.status);
          end
          if (mon_got.amp_re != mon_want.amp_re) begin
            errors++;
            $display("%0t: amp_re expected %0d actual %0d", $time, mon_want.amp_re, mon_got.amp_re);
          end
          if (mon_got.amp_im != mon_want.amp_im) begin
            errors++;
            $display("%0t: amp_im expected %0d actual %0d", $time, mon_want.amp_im, mon_got.amp_im);
          end
        end
        stall_nxt = quiet ? 0 : $urandom_range(0, 11);
      end else if (stall_nxt != 0 && hold_left == 0) begin
        stall_nxt = stall_nxt - 1;
      end
      stall_cnt <= stall_nxt;
      m_axis_tready <= (stall_nxt == 0) && (hold_left == 0);
    end
  end

  initial begin
    foreach (state_amp[i]) begin
      state_amp[i] = '0;
      accum_amp[i] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // full-range values, saturation both ways, rounding toward minus infinity
    queue_req(CMD_LOAD, 0, 0, 16'sh7fff, 16'sh8000);
    queue_req(CMD_LOAD, 1023, 0, 16'sh8000, 16'sh7fff);
    queue_req(CMD_LOAD, 5, 0, 16'sh4000, 16'sh0000);
    queue_req(CMD_READ, 0, 0, 16'sh0000, 16'sh0000);
    queue_req(CMD_READ, 1023, 1023, 16'sh7fff, 16'sh7fff);
    queue_req(CMD_ACC, 0, 0, 16'sh7fff, 16'sh7fff);
    queue_req(CMD_ACC, 0, 0, 16'sh8000, 16'sh8000);
    queue_req(CMD_ACC, 1023, 5, 16'shffff, 16'shffff);
    queue_req(CMD_ACC, 1023, 1023, 16'sh8000, 16'sh8000);
    queue_req(CMD_ACC, 3, 5, 16'sh4000, 16'sh4000);
    queue_req(CMD_COMMIT, 1023, 1023, 16'sh7fff, 16'sh8000);
    queue_req(CMD_READ, 0, 0, 16'sh0000, 16'sh0000);
    queue_req(CMD_READ, 1023, 0, 16'sh0000, 16'sh0000);
    queue_req(CMD_READ, 3, 0, 16'sh0000, 16'sh0000);
    queue_req(CMD_READ, 5, 0, 16'sh0000, 16'sh0000);

    // index range checks on a two-entry vector
    write_qubits(4'd1);
    queue_req(CMD_LOAD, 1, 0, 16'sh1234, 16'shedcb);
    queue_req(CMD_LOAD, 2, 0, 16'sh1111, 16'sh2222);
    queue_req(CMD_READ, 2, 0, 16'sh0000, 16'sh0000);
    queue_req(CMD_ACC, 1, 2, 16'sh4000, 16'sh0000);
    queue_req(CMD_ACC, 2, 1, 16'sh4000, 16'sh0000);
    queue_req(CMD_READ, 1, 0, 16'sh0000, 16'sh0000);

    // a single-entry vector
    write_qubits(4'd0);
    queue_req(CMD_LOAD, 1, 0, 16'sh0001, 16'sh0001);
    queue_req(CMD_READ, 0, 0, 16'sh0000, 16'sh0000);

    // qubit count beyond the maximum is clamped
    write_qubits(4'd15);
    queue_req(CMD_LOAD, 1023, 0, 16'sh2aaa, 16'sh5555);
    queue_req(CMD_READ, 1023, 0, 16'sh0000, 16'sh0000);

    foreach (phase_qubits[p]) begin
      write_qubits(phase_qubits[p][QC_W-1:0]);
      quiet = ($urandom_range(0, 3) == 0);
      begin : fill_phase
        int start;
        start = queued_cnt;
        while (queued_cnt - start < 210) add_round(vec_len());
      end
    end

    wait_idle();
    repeat (32) @(negedge clk_i);
    if (errors == 0 && expected_amps.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
